/* hdl/vzp_pkg.sv */
// Shared types, constants and helpers for the viewport zoom/pan tracker.
`default_nettype none

package vzp_pkg;

    // World and panel geometry in pixels.
    localparam int WORLD_WIDTH  = 1280;
    localparam int WORLD_HEIGHT = 960;
    localparam int VIEW_WIDTH   = 320;
    localparam int VIEW_HEIGHT  = 240;

    // Zoom codes: 25 << code percent.
    localparam logic [2:0] ZOOM_OVERVIEW = 3'd0;
    localparam logic [2:0] ZOOM_MAX      = 3'd4;

    // Item modes.
    localparam logic MODE_ZOOM = 1'b0;
    localparam logic MODE_PAN  = 1'b1;

    // Largest focus distance, in quarter-world units, for reusing a saved view.
    localparam int MATCH_TOL = 4;

    // Viewport origin and retained focus of the active level.
    typedef struct packed {
        logic [2:0]  zoom;
        logic [12:0] ox;
        logic [11:0] oy;
        logic [12:0] fx;
        logic [11:0] fy;
    } t_view_state;

    // One remembered view of a tiled level.
    typedef struct packed {
        logic [12:0] ox;
        logic [11:0] oy;
        logic [12:0] fx;
        logic [11:0] fy;
    } t_saved;

    // Write port into the saved-view store.
    typedef struct packed {
        logic       en;
        logic [1:0] idx;
        t_saved     data;
    } t_save_wr;

    // Pan-edge flags.
    typedef struct packed {
        logic up;
        logic left;
        logic right;
        logic down;
    } t_pan_flags;

    // Largest x origin at a tiled level.
    function automatic logic signed [15:0] max_org_x(input logic [2:0] z);
        int w;
        w = (WORLD_WIDTH << z) >> 2;
        return 16'(w - VIEW_WIDTH);
    endfunction

    // Largest y origin at a tiled level.
    function automatic logic signed [15:0] max_org_y(input logic [2:0] z);
        int h;
        h = (WORLD_HEIGHT << z) >> 2;
        return 16'(h - VIEW_HEIGHT);
    endfunction

    // Limit to hi first, then floor at zero.
    function automatic logic signed [15:0] clamp_org(input logic signed [15:0] v,
                                                     input logic signed [15:0] hi);
        logic signed [15:0] r;
        r = (v > hi) ? hi : v;
        if (r < 16'sd0) begin
            r = 16'sd0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/viewport_zoom_pan_tracker.sv */
// Top level of the viewport zoom/pan tracker: state, saved views and result register.
`default_nettype none

// Takes one zoom or pan beat per clock while the output is not stalled and returns
// one result beat in the cycle after it is accepted. The whole update (focus rescaling
// by shifts, origin clamps and the saved-view match) is a single combinational pass
// from the held state and the input beat into the state and the result register, so
// the block sustains one beat per cycle. A result waiting on the output does
// not stall the input unless the downstream side holds i_ready low; the input
// is ready whenever the result register is empty or being emptied. The four
// saved views live in flip-flops with a valid bit each, cleared by reset.

module viewport_zoom_pan_tracker (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    input  wire                i_mode,
    input  wire [2:0]          i_zoom_req,
    input  wire signed [13:0]  i_request_x,
    input  wire signed [13:0]  i_request_y,
    input  wire signed [10:0]  i_panel_focus_x,
    input  wire signed [10:0]  i_panel_focus_y,
    output logic               o_valid,
    input  wire                i_ready,
    output logic               o_accepted,
    output logic [2:0]         o_zoom_now,
    output logic [12:0]        o_view_x,
    output logic [11:0]        o_view_y,
    output logic [12:0]        o_focus_quarter_x,
    output logic [11:0]        o_focus_quarter_y,
    output logic               o_can_pan_up,
    output logic               o_can_pan_left,
    output logic               o_can_pan_right,
    output logic               o_can_pan_down
);

    vzp_pkg::t_view_state r_state;
    vzp_pkg::t_view_state n_state;
    vzp_pkg::t_saved      r_saved [4];
    logic [3:0]           r_saved_valid;
    logic                 r_out_valid;
    logic                 r_accepted;
    vzp_pkg::t_view_state r_res;
    vzp_pkg::t_pan_flags  r_flags;
    vzp_pkg::t_pan_flags  n_flags;
    vzp_pkg::t_save_wr    save_wr;
    logic [1:0]           rd_idx;
    logic                 ok;
    logic                 in_fire;

    // Accept a beat when the result register is empty or draining.
    assign o_ready = !r_out_valid || i_ready;
    assign in_fire = i_valid && o_ready;

    vzp_next u_next (
        .i_cur           (r_state),
        .i_mode          (i_mode),
        .i_zoom_req      (i_zoom_req),
        .i_request_x     (i_request_x),
        .i_request_y     (i_request_y),
        .i_panel_focus_x (i_panel_focus_x),
        .i_panel_focus_y (i_panel_focus_y),
        .i_rd_entry      (r_saved[rd_idx]),
        .i_rd_valid      (r_saved_valid[rd_idx]),
        .o_rd_idx        (rd_idx),
        .o_ok            (ok),
        .o_next          (n_state),
        .o_save          (save_wr),
        .o_flags         (n_flags)
    );

    // Advance the viewport state and its valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= '0;
            r_saved_valid <= '0;
        end else if (in_fire) begin
            r_state <= n_state;
            if (save_wr.en) begin
                r_saved_valid[save_wr.idx] <= 1'b1;
            end
        end
    end

    // Write the saved view of the level being left.
    always_ff @(posedge i_clk) begin
        if (in_fire && save_wr.en) begin
            r_saved[save_wr.idx] <= save_wr.data;
        end
    end

    // Hold the result beat until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Capture the result of each accepted beat.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_accepted <= ok;
            r_res      <= n_state;
            r_flags    <= n_flags;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_accepted        = r_accepted;
    assign o_zoom_now        = r_res.zoom;
    assign o_view_x          = r_res.ox;
    assign o_view_y          = r_res.oy;
    assign o_focus_quarter_x = r_res.fx;
    assign o_focus_quarter_y = r_res.fy;
    assign o_can_pan_up      = r_flags.up;
    assign o_can_pan_left    = r_flags.left;
    assign o_can_pan_right   = r_flags.right;
    assign o_can_pan_down    = r_flags.down;

endmodule

`default_nettype wire

/* hdl/vzp_next.sv */
// Next-state and result logic for one zoom or pan item.
`default_nettype none

module vzp_next (
    input  wire vzp_pkg::t_view_state i_cur,
    input  wire                       i_mode,
    input  wire [2:0]                 i_zoom_req,
    input  wire signed [13:0]         i_request_x,
    input  wire signed [13:0]         i_request_y,
    input  wire signed [10:0]         i_panel_focus_x,
    input  wire signed [10:0]         i_panel_focus_y,
    input  wire vzp_pkg::t_saved      i_rd_entry,
    input  wire                       i_rd_valid,
    output logic [1:0]                o_rd_idx,
    output logic                      o_ok,
    output vzp_pkg::t_view_state      o_next,
    output vzp_pkg::t_save_wr         o_save,
    output vzp_pkg::t_pan_flags       o_flags
);

    logic [2:0]         tz;
    logic [9:0]         pfx;
    logic [9:0]         pfy;
    logic               ok;
    logic signed [15:0] pan_ox;
    logic signed [15:0] pan_oy;
    logic [12:0]        base_ox;
    logic [11:0]        base_oy;
    logic [13:0]        sum_x;
    logic [12:0]        sum_y;
    logic [2:0]         up_sh;
    logic [12:0]        sv_fx;
    logic [11:0]        sv_fy;
    logic [12:0]        fcx;
    logic [11:0]        fcy;
    logic [17:0]        lvx;
    logic [16:0]        lvy;
    logic [13:0]        flx;
    logic [12:0]        fly;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [13:0] dx;
    logic signed [12:0] dy;
    logic               match;
    logic               in_view;
    logic signed [15:0] mxn;
    logic signed [15:0] myn;

    // Saturate the zoom code and qualify the panel focus.
    always_comb begin
        tz  = (i_zoom_req > vzp_pkg::ZOOM_MAX) ? vzp_pkg::ZOOM_MAX : i_zoom_req;
        pfx = i_panel_focus_x[9:0];
        pfy = i_panel_focus_y[9:0];
        ok  = !i_panel_focus_x[10] && !i_panel_focus_y[10] &&
              ({1'b0, pfx} < 11'(vzp_pkg::VIEW_WIDTH)) &&
              ({1'b0, pfy} < 11'(vzp_pkg::VIEW_HEIGHT));
    end

    // Clamp a pan request to the current level.
    always_comb begin
        pan_ox = vzp_pkg::clamp_org(16'(i_request_x), vzp_pkg::max_org_x(i_cur.zoom));
        pan_oy = vzp_pkg::clamp_org(16'(i_request_y), vzp_pkg::max_org_y(i_cur.zoom));
    end

    // Focus of the view being left, in quarter-world units.
    always_comb begin
        base_ox = (i_mode == vzp_pkg::MODE_PAN) ? pan_ox[12:0] : i_cur.ox;
        base_oy = (i_mode == vzp_pkg::MODE_PAN) ? pan_oy[11:0] : i_cur.oy;
        sum_x   = {1'b0, base_ox} + {4'b0, pfx};
        sum_y   = {1'b0, base_oy} + {3'b0, pfy};
        up_sh   = vzp_pkg::ZOOM_MAX - i_cur.zoom;
        sv_fx   = sum_x[12:0] << up_sh;
        sv_fy   = sum_y[11:0] << up_sh;
    end

    // Retained focus mapped onto the target level, and the centered origin.
    always_comb begin
        fcx = (i_cur.zoom != vzp_pkg::ZOOM_OVERVIEW) ? sv_fx : i_cur.fx;
        fcy = (i_cur.zoom != vzp_pkg::ZOOM_OVERVIEW) ? sv_fy : i_cur.fy;
        lvx = ({5'b0, fcx} << tz) + 18'd8;
        lvy = ({5'b0, fcy} << tz) + 17'd8;
        flx = lvx[17:4];
        fly = lvy[16:4];
        cx  = vzp_pkg::clamp_org($signed({2'b0, flx}) - $signed({6'b0, pfx}),
                                 vzp_pkg::max_org_x(tz));
        cy  = vzp_pkg::clamp_org($signed({3'b0, fly}) - $signed({6'b0, pfy}),
                                 vzp_pkg::max_org_y(tz));
    end

    // Check whether the target level's saved view can be reused.
    always_comb begin
        o_rd_idx = 2'(tz - 3'd1);
        dx       = $signed({1'b0, i_rd_entry.fx}) - $signed({1'b0, fcx});
        dy       = $signed({1'b0, i_rd_entry.fy}) - $signed({1'b0, fcy});
        match    = (dx >= -14'(vzp_pkg::MATCH_TOL)) && (dx <= 14'(vzp_pkg::MATCH_TOL)) &&
                   (dy >= -13'(vzp_pkg::MATCH_TOL)) && (dy <= 13'(vzp_pkg::MATCH_TOL));
        in_view  = ({2'b0, flx} >= {3'b0, i_rd_entry.ox}) &&
                   ({2'b0, flx} < ({3'b0, i_rd_entry.ox} + 16'(vzp_pkg::VIEW_WIDTH))) &&
                   ({3'b0, fly} >= {4'b0, i_rd_entry.oy}) &&
                   ({3'b0, fly} < ({4'b0, i_rd_entry.oy} + 16'(vzp_pkg::VIEW_HEIGHT)));
    end

    // Select the next state and the store write.
    always_comb begin
        o_next           = i_cur;
        o_save.en        = 1'b0;
        o_save.idx       = 2'(i_cur.zoom - 3'd1);
        o_save.data.ox   = base_ox;
        o_save.data.oy   = base_oy;
        o_save.data.fx   = sv_fx;
        o_save.data.fy   = sv_fy;
        if (ok && i_mode == vzp_pkg::MODE_PAN) begin
            if (i_cur.zoom == vzp_pkg::ZOOM_OVERVIEW) begin
                o_next.ox = '0;
                o_next.oy = '0;
            end else begin
                o_next.ox = pan_ox[12:0];
                o_next.oy = pan_oy[11:0];
                o_next.fx = sv_fx;
                o_next.fy = sv_fy;
                o_save.en = 1'b1;
            end
        end else if (ok && tz != i_cur.zoom) begin
            if (i_cur.zoom != vzp_pkg::ZOOM_OVERVIEW) begin
                o_save.en = 1'b1;
            end
            o_next.fx   = fcx;
            o_next.fy   = fcy;
            o_next.zoom = tz;
            if (tz == vzp_pkg::ZOOM_OVERVIEW) begin
                o_next.ox = '0;
                o_next.oy = '0;
            end else if (i_rd_valid && match && in_view) begin
                o_next.ox = i_rd_entry.ox;
                o_next.oy = i_rd_entry.oy;
            end else begin
                o_next.ox = cx[12:0];
                o_next.oy = cy[11:0];
            end
        end
    end

    // Pan-edge flags of the state after the item.
    always_comb begin
        mxn = vzp_pkg::max_org_x(o_next.zoom);
        myn = vzp_pkg::max_org_y(o_next.zoom);
        if (o_next.zoom == vzp_pkg::ZOOM_OVERVIEW) begin
            o_flags = '0;
        end else begin
            o_flags.up    = (o_next.oy != '0);
            o_flags.left  = (o_next.ox != '0);
            o_flags.right = ($signed({3'b0, o_next.ox}) < mxn);
            o_flags.down  = ($signed({4'b0, o_next.oy}) < myn);
        end
    end

    assign o_ok = ok;

endmodule

`default_nettype wire

/* hdl/vzp_checker.sv */
// Port-level checks for the viewport zoom/pan tracker, bound to the top level.
`default_nettype none

module vzp_checker (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               i_valid,
    input wire               o_ready,
    input wire               o_valid,
    input wire               i_ready,
    input wire [2:0]         o_zoom_now,
    input wire [12:0]        o_view_x,
    input wire [11:0]        o_view_y,
    input wire               o_can_pan_up,
    input wire               o_can_pan_left,
    input wire               o_can_pan_right,
    input wire               o_can_pan_down
);

    // A stalled result beat stays up.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid)
        else $error("result beat dropped while stalled");

    // Every accepted beat shows a result in the next cycle.
    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> o_valid)
        else $error("accepted beat produced no result");

    // The zoom code never leaves its range.
    a_zoom_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_zoom_now <= vzp_pkg::ZOOM_MAX))
        else $error("zoom code out of range");

    // The overview is pinned at the origin with no pan edges.
    a_overview: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zoom_now == vzp_pkg::ZOOM_OVERVIEW) |->
            (o_view_x == 13'd0 && o_view_y == 12'd0 && !o_can_pan_up &&
             !o_can_pan_left && !o_can_pan_right && !o_can_pan_down))
        else $error("overview shows a nonzero origin or pan edge");

endmodule

bind viewport_zoom_pan_tracker vzp_checker u_vzp_checker (.*);

`default_nettype wire

/* tb/viewport_tracker_monitor.sv */
// Channel monitor for the viewport zoom/pan tracker: predicts every result beat and checks it.
`timescale 1ns / 100ps

module viewport_tracker_monitor (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    input  wire               i_in_ready,
    input  wire               i_mode,
    input  wire [2:0]         i_zoom_req,
    input  wire signed [13:0] i_request_x,
    input  wire signed [13:0] i_request_y,
    input  wire signed [10:0] i_panel_focus_x,
    input  wire signed [10:0] i_panel_focus_y,
    input  wire               i_out_valid,
    input  wire               i_out_ready,
    input  wire               i_accepted,
    input  wire [2:0]         i_zoom_now,
    input  wire [12:0]        i_view_x,
    input  wire [11:0]        i_view_y,
    input  wire [12:0]        i_focus_quarter_x,
    input  wire [11:0]        i_focus_quarter_y,
    input  wire               i_can_pan_up,
    input  wire               i_can_pan_left,
    input  wire               i_can_pan_right,
    input  wire               i_can_pan_down,
    output int                o_errors,
    output int                o_pending,
    output int                o_checked,
    output int                o_rejected,
    output int                o_reused
);

    localparam int         WORLD_WIDTH   = vzp_pkg::WORLD_WIDTH;
    localparam int         WORLD_HEIGHT  = vzp_pkg::WORLD_HEIGHT;
    localparam int         VIEW_WIDTH    = vzp_pkg::VIEW_WIDTH;
    localparam int         VIEW_HEIGHT   = vzp_pkg::VIEW_HEIGHT;
    localparam int         MATCH_TOL     = vzp_pkg::MATCH_TOL;
    localparam logic [2:0] ZOOM_OVERVIEW = vzp_pkg::ZOOM_OVERVIEW;
    localparam logic [2:0] ZOOM_MAX      = vzp_pkg::ZOOM_MAX;
    localparam logic       MODE_PAN      = vzp_pkg::MODE_PAN;

    // One result beat as the tracker reports it.
    typedef struct packed {
        logic                acc;
        logic [2:0]          zoom;
        logic [12:0]         vx;
        logic [11:0]         vy;
        logic [12:0]         fqx;
        logic [11:0]         fqy;
        vzp_pkg::t_pan_flags pan;
    } t_view_report;

    // Predicted tracker state.
    vzp_pkg::t_view_state view_now;
    vzp_pkg::t_saved      views_kept [4];
    logic [3:0]           kept_valid;
    t_view_report         pending_views [$];

    // Largest origin along one axis at zoom code z.
    function automatic int level_max(input int world, input int view, input int z);
        return ((world << z) / 4) - view;
    endfunction

    // Limit to the maximum first, then floor at zero.
    function automatic int limit_origin(input int v, input int hi);
        int r;
        r = (v > hi) ? hi : v;
        if (r < 0) begin
            r = 0;
        end
        return r;
    endfunction

    // Quarter-world focus to level pixels, rounding half up.
    function automatic int to_level_px(input int fq, input int z);
        return ((fq << z) + 8) >> 4;
    endfunction

    // Recompute the focus from the current view and remember it for this level.
    function automatic void stash_level(input int pfx, input int pfy);
        int z;
        int idx;
        z = view_now.zoom;
        idx = (z - 1) & 3;
        view_now.fx = 13'((int'(view_now.ox) + pfx) << (4 - z));
        view_now.fy = 12'((int'(view_now.oy) + pfy) << (4 - z));
        views_kept[idx].ox = view_now.ox;
        views_kept[idx].oy = view_now.oy;
        views_kept[idx].fx = view_now.fx;
        views_kept[idx].fy = view_now.fy;
        kept_valid[idx] = 1'b1;
    endfunction

    // Apply one input beat to the predicted state and return the result it causes.
    function automatic t_view_report advance_view(input logic mode, input logic [2:0] tz_in,
                                                  input int rx, input int ry,
                                                  input int pfx, input int pfy);
        t_view_report rep;
        logic ok;
        logic near;
        logic covers;
        int tz;
        int zc;
        int idx;
        int flx;
        int fly;
        int cx;
        int cy;
        int dx;
        int dy;
        int mx;
        int my;
        ok = pfx >= 0 && pfy >= 0 && pfx < VIEW_WIDTH && pfy < VIEW_HEIGHT;
        tz = (tz_in > ZOOM_MAX) ? int'(ZOOM_MAX) : int'(tz_in);
        zc = view_now.zoom;
        if (!ok) begin
            o_rejected++;
        end
        if (ok && mode == MODE_PAN) begin
            // Pan: the overview stays pinned at zero, tiled levels clamp and save.
            if (zc == ZOOM_OVERVIEW) begin
                view_now.ox = '0;
                view_now.oy = '0;
            end else begin
                view_now.ox = 13'(limit_origin(rx, level_max(WORLD_WIDTH, VIEW_WIDTH, zc)));
                view_now.oy = 12'(limit_origin(ry, level_max(WORLD_HEIGHT, VIEW_HEIGHT, zc)));
                stash_level(pfx, pfy);
            end
        end else if (ok && tz != zc) begin
            // Zoom change: save the level being left, then reuse or centre.
            if (zc != ZOOM_OVERVIEW) begin
                stash_level(pfx, pfy);
            end
            view_now.zoom = 3'(tz);
            if (tz == ZOOM_OVERVIEW) begin
                view_now.ox = '0;
                view_now.oy = '0;
            end else begin
                idx = (tz - 1) & 3;
                flx = to_level_px(view_now.fx, tz);
                fly = to_level_px(view_now.fy, tz);
                cx = limit_origin(flx - pfx, level_max(WORLD_WIDTH, VIEW_WIDTH, tz));
                cy = limit_origin(fly - pfy, level_max(WORLD_HEIGHT, VIEW_HEIGHT, tz));
                dx = int'(views_kept[idx].fx) - int'(view_now.fx);
                dy = int'(views_kept[idx].fy) - int'(view_now.fy);
                near = dx <= MATCH_TOL && dx >= -MATCH_TOL && dy <= MATCH_TOL && dy >= -MATCH_TOL;
                covers = flx >= int'(views_kept[idx].ox) &&
                         flx < int'(views_kept[idx].ox) + VIEW_WIDTH &&
                         fly >= int'(views_kept[idx].oy) &&
                         fly < int'(views_kept[idx].oy) + VIEW_HEIGHT;
                if (kept_valid[idx] && near && covers) begin
                    view_now.ox = views_kept[idx].ox;
                    view_now.oy = views_kept[idx].oy;
                    o_reused++;
                end else begin
                    view_now.ox = 13'(cx);
                    view_now.oy = 12'(cy);
                end
            end
        end

        // Report from the state after the beat.
        rep.acc = ok;
        rep.zoom = view_now.zoom;
        rep.vx = view_now.ox;
        rep.vy = view_now.oy;
        rep.fqx = view_now.fx;
        rep.fqy = view_now.fy;
        rep.pan = '0;
        if (view_now.zoom != ZOOM_OVERVIEW) begin
            mx = level_max(WORLD_WIDTH, VIEW_WIDTH, view_now.zoom);
            my = level_max(WORLD_HEIGHT, VIEW_HEIGHT, view_now.zoom);
            rep.pan.up = view_now.oy > 0;
            rep.pan.left = view_now.ox > 0;
            rep.pan.right = int'(view_now.ox) < mx;
            rep.pan.down = int'(view_now.oy) < my;
        end
        return rep;
    endfunction

    task automatic check_field(input string name, input logic [12:0] want,
                               input logic [12:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_errors++;
        end
    endtask

    // Compare result beats first, then queue the prediction for a new input beat.
    always @(posedge i_clk) begin
        t_view_report want;
        if (!i_rst_n) begin
            view_now = '0;
            kept_valid = '0;
            for (int k = 0; k < 4; k++) begin
                views_kept[k] = '0;
            end
            pending_views.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_views.size() == 0) begin
                    $error("result beat with no prediction pending");
                    o_errors++;
                end else begin
                    want = pending_views.pop_front();
                    o_checked++;
                    check_field("accepted", 13'(want.acc), 13'(i_accepted));
                    check_field("zoom_now", 13'(want.zoom), 13'(i_zoom_now));
                    check_field("view_x", want.vx, i_view_x);
                    check_field("view_y", 13'(want.vy), 13'(i_view_y));
                    check_field("focus_quarter_x", want.fqx, i_focus_quarter_x);
                    check_field("focus_quarter_y", 13'(want.fqy), 13'(i_focus_quarter_y));
                    check_field("can_pan_up", 13'(want.pan.up), 13'(i_can_pan_up));
                    check_field("can_pan_left", 13'(want.pan.left), 13'(i_can_pan_left));
                    check_field("can_pan_right", 13'(want.pan.right), 13'(i_can_pan_right));
                    check_field("can_pan_down", 13'(want.pan.down), 13'(i_can_pan_down));
                end
            end
            if (i_in_valid && i_in_ready) begin
                pending_views.push_back(advance_view(i_mode, i_zoom_req,
                                                     int'(i_request_x), int'(i_request_y),
                                                     int'(i_panel_focus_x),
                                                     int'(i_panel_focus_y)));
            end
        end
        o_pending = pending_views.size();
    end

endmodule

/* tb/viewport_zoom_pan_tracker_tb.sv */
// Stimulus, flow control and verdict for the viewport zoom/pan tracker.
`timescale 1ns / 100ps

module viewport_zoom_pan_tracker_tb;

    localparam logic       MODE_ZOOM     = vzp_pkg::MODE_ZOOM;
    localparam logic       MODE_PAN      = vzp_pkg::MODE_PAN;
    localparam logic [2:0] ZOOM_OVERVIEW = vzp_pkg::ZOOM_OVERVIEW;
    localparam logic [2:0] ZOOM_MAX      = vzp_pkg::ZOOM_MAX;
    localparam int         VIEW_WIDTH    = vzp_pkg::VIEW_WIDTH;
    localparam int         VIEW_HEIGHT   = vzp_pkg::VIEW_HEIGHT;

    // Tiled zoom codes between the overview and the top level.
    localparam logic [2:0] ZOOM_HALF   = 3'd1;
    localparam logic [2:0] ZOOM_FULL   = 3'd2;
    localparam logic [2:0] ZOOM_DOUBLE = 3'd3;

    localparam int RANDOM_BEATS = 1900;
    localparam int DRAIN_CYCLES = 8;

    logic               i_clk;
    logic               i_rst_n;
    logic               in_valid;
    wire                in_ready;
    logic               mode;
    logic [2:0]         zoom_req;
    logic signed [13:0] request_x;
    logic signed [13:0] request_y;
    logic signed [10:0] panel_focus_x;
    logic signed [10:0] panel_focus_y;
    wire                out_valid;
    logic               out_ready;
    wire                accepted;
    wire [2:0]          zoom_now;
    wire [12:0]         view_x;
    wire [11:0]         view_y;
    wire [12:0]         focus_quarter_x;
    wire [11:0]         focus_quarter_y;
    wire                can_pan_up;
    wire                can_pan_left;
    wire                can_pan_right;
    wire                can_pan_down;

    int errors;
    int pending;
    int checked;
    int rejected;
    int reused;
    int send_idle_pct;
    int recv_idle_pct;
    int anchor_x;
    int anchor_y;

    viewport_zoom_pan_tracker DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (in_valid),
        .o_ready           (in_ready),
        .i_mode            (mode),
        .i_zoom_req        (zoom_req),
        .i_request_x       (request_x),
        .i_request_y       (request_y),
        .i_panel_focus_x   (panel_focus_x),
        .i_panel_focus_y   (panel_focus_y),
        .o_valid           (out_valid),
        .i_ready           (out_ready),
        .o_accepted        (accepted),
        .o_zoom_now        (zoom_now),
        .o_view_x          (view_x),
        .o_view_y          (view_y),
        .o_focus_quarter_x (focus_quarter_x),
        .o_focus_quarter_y (focus_quarter_y),
        .o_can_pan_up      (can_pan_up),
        .o_can_pan_left    (can_pan_left),
        .o_can_pan_right   (can_pan_right),
        .o_can_pan_down    (can_pan_down)
    );

    viewport_tracker_monitor monitor (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_mode            (mode),
        .i_zoom_req        (zoom_req),
        .i_request_x       (request_x),
        .i_request_y       (request_y),
        .i_panel_focus_x   (panel_focus_x),
        .i_panel_focus_y   (panel_focus_y),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_accepted        (accepted),
        .i_zoom_now        (zoom_now),
        .i_view_x          (view_x),
        .i_view_y          (view_y),
        .i_focus_quarter_x (focus_quarter_x),
        .i_focus_quarter_y (focus_quarter_y),
        .i_can_pan_up      (can_pan_up),
        .i_can_pan_left    (can_pan_left),
        .i_can_pan_right   (can_pan_right),
        .i_can_pan_down    (can_pan_down),
        .o_errors          (errors),
        .o_pending         (pending),
        .o_checked         (checked),
        .o_rejected        (rejected),
        .o_reused          (reused)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Stall the result channel at random
    always @(negedge i_clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Hold off at random, then present one beat and hold it until it is taken.
    task automatic send_view(input logic m, input logic [2:0] tz, input int rx, input int ry,
                             input int pfx, input int pfy);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        zoom_req <= tz;
        request_x <= 14'(rx);
        request_y <= 14'(ry);
        panel_focus_x <= 11'(pfx);
        panel_focus_y <= 11'(pfy);
        @(posedge i_clk);
        while (!in_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // Mostly in-panel focus that sticks across beats so saved views get reused.
    task automatic random_view();
        logic [2:0] tz;
        int rx;
        int ry;
        int pfx;
        int pfy;
        int pick;
        pick = $urandom_range(99);
        if (pick < 60) begin
            pfx = anchor_x;
            pfy = anchor_y;
        end else if (pick < 85) begin
            anchor_x = $urandom_range(VIEW_WIDTH - 1);
            anchor_y = $urandom_range(VIEW_HEIGHT - 1);
            pfx = anchor_x;
            pfy = anchor_y;
        end else if (pick < 93) begin
            pfx = $signed(11'($urandom()));
            pfy = $signed(11'($urandom()));
        end else begin
            // Just inside or just outside the panel edges
            pfx = $urandom_range(1) ? VIEW_WIDTH - $urandom_range(1) : $urandom_range(1) - 1;
            pfy = $urandom_range(1) ? VIEW_HEIGHT - $urandom_range(1) : $urandom_range(1) - 1;
        end
        tz = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
        pick = $urandom_range(99);
        if (pick < 60) begin
            rx = $urandom_range(5200);
            ry = $urandom_range(3900);
        end else if (pick < 80) begin
            rx = $urandom_range(64) - 32;
            ry = $urandom_range(64) - 32;
        end else begin
            rx = $signed(14'($urandom()));
            ry = $signed(14'($urandom()));
        end
        send_view(1'($urandom_range(1)), tz, rx, ry, pfx, pfy);
    endtask

    task automatic random_phase(input int beats);
        repeat (beats) begin
            random_view();
        end
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        mode = MODE_ZOOM;
        zoom_req = ZOOM_OVERVIEW;
        request_x = '0;
        request_y = '0;
        panel_focus_x = '0;
        panel_focus_y = '0;
        out_ready = 1'b0;
        send_idle_pct = 15;
        recv_idle_pct = 78;
        anchor_x = VIEW_WIDTH / 2;
        anchor_y = VIEW_HEIGHT / 2;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Overview: same zoom, pinned pan, rejected focus past the left, right and bottom edges
        send_view(MODE_ZOOM, ZOOM_OVERVIEW, 0, 0, 0, 0);
        send_view(MODE_PAN, ZOOM_OVERVIEW, 8191, -8192, VIEW_WIDTH - 1, VIEW_HEIGHT - 1);
        send_view(MODE_ZOOM, ZOOM_MAX, 0, 0, -1, 0);
        send_view(MODE_ZOOM, ZOOM_MAX, 0, 0, VIEW_WIDTH, 100);
        send_view(MODE_PAN, ZOOM_MAX, 100, 100, 100, VIEW_HEIGHT);
        send_view(MODE_PAN, ZOOM_FULL, -8192, 8191, -1024, 1023);
        // Leave the overview, pan, zoom in and come back to the saved view
        send_view(MODE_ZOOM, ZOOM_FULL, 0, 0, 160, 120);
        send_view(MODE_PAN, ZOOM_FULL, 100, 100, 160, 120);
        send_view(MODE_ZOOM, ZOOM_DOUBLE, 0, 0, 160, 120);
        send_view(MODE_ZOOM, ZOOM_FULL, 0, 0, 160, 120);
        // Pan clamps at both ends
        send_view(MODE_PAN, ZOOM_FULL, -8192, -8192, 0, 0);
        send_view(MODE_PAN, ZOOM_FULL, 8191, 8191, VIEW_WIDTH - 1, VIEW_HEIGHT - 1);
        // Saturating zoom codes and the top level at its extremes
        send_view(MODE_ZOOM, 3'd7, 0, 0, VIEW_WIDTH - 1, VIEW_HEIGHT - 1);
        send_view(MODE_ZOOM, ZOOM_MAX, 0, 0, 10, 10);
        send_view(MODE_PAN, ZOOM_MAX, 4800, 3600, VIEW_WIDTH - 1, VIEW_HEIGHT - 1);
        send_view(MODE_ZOOM, 3'd5, 0, 0, 0, 0);
        send_view(MODE_ZOOM, ZOOM_HALF, 0, 0, 0, 0);
        send_view(MODE_PAN, ZOOM_HALF, 8191, 8191, VIEW_WIDTH - 1, VIEW_HEIGHT - 1);
        send_view(MODE_ZOOM, 3'd6, 0, 0, 1023, -1024);
        send_view(MODE_ZOOM, ZOOM_OVERVIEW, 0, 0, 5, 5);
        send_view(MODE_ZOOM, ZOOM_DOUBLE, 0, 0, VIEW_WIDTH - 1, VIEW_HEIGHT - 1);
        send_view(MODE_ZOOM, ZOOM_HALF, 0, 0, 0, VIEW_HEIGHT - 1);
        send_view(MODE_ZOOM, ZOOM_OVERVIEW, 0, 0, 0, 0);
        send_view(MODE_ZOOM, ZOOM_MAX, 0, 0, 160, 120);

        // Random traffic under three flow-control mixes
        random_phase(RANDOM_BEATS / 3);
        send_idle_pct = 78;
        recv_idle_pct = 15;
        random_phase(RANDOM_BEATS / 3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(RANDOM_BEATS - 2 * (RANDOM_BEATS / 3));
        in_valid <= 1'b0;

        // Drain, then give stray results a chance to show up
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Checked %0d result beats: %0d with rejected focus, %0d saved views reused.",
                 checked, rejected, reused);
        $display("Covered every zoom code, pan clamps at each level and three stall mixes.");
        if (errors == 0) begin
            $display("viewport_zoom_pan_tracker_tb: done, clean");
        end else begin
            $display("viewport_zoom_pan_tracker_tb: done, errors");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2ms;
        $display("viewport_zoom_pan_tracker_tb: done, errors");
        $finish;
    end

endmodule
